/* rtl/sensor_bank_change_detector_defines.svh */
// ---------------------------------------------------------------------------
// Sensor bank change detector - assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ---------------------------------------------------------------------------
`ifndef SENSOR_BANK_CHANGE_DETECTOR_DEFINES_SVH
`define SENSOR_BANK_CHANGE_DETECTOR_DEFINES_SVH

// condition holds at every edge out of reset
`define SBCD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define SBCD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define SBCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sbcd_pkg.sv */
// ---------------------------------------------------------------------------
// Sensor bank change detector - package
// Widths, register indexes, job word passed from front to back, helpers.
// ---------------------------------------------------------------------------
`default_nettype none

package sbcd_pkg;

  localparam int MAX_BANKS       = 5;
  localparam int SENSORS         = 16;
  localparam int BYTE_W          = 8;
  localparam int TICK_W          = 32;
  localparam int POS_W           = 4;
  localparam int BANK_W          = 3;
  localparam int NUM_W           = 5;
  localparam int SIDX_W          = 4;
  localparam int CFG_IDX_W       = 8;
  localparam int CFG_DATA_W      = 64;
  localparam int LOW_W           = 64;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PRESENT_LOW  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PRESENT_HIGH = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_MUTE_LOW     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_MUTE_HIGH    = CFG_IDX_W'(3);

  localparam logic REQ_BYTE    = 1'b0;
  localparam logic REQ_RESTART = 1'b1;

  typedef logic [SENSORS-1:0] sensor_vec_t;

  typedef struct packed {
    logic [BANK_W-1:0] bank;
    sensor_vec_t       levels;
    sensor_vec_t       act;
    sensor_vec_t       emit;
    logic [TICK_W-1:0] tick;
  } sbcd_job_t;

  function automatic logic [BYTE_W-1:0] flip_byte(input logic [BYTE_W-1:0] v);
    logic [BYTE_W-1:0] r;
    for (int i = 0; i < BYTE_W; i++) r[i] = v[BYTE_W-1-i];
    return r;
  endfunction

  function automatic sensor_vec_t bank_mask(input logic [LOW_W-1:0] lo,
                                            input sensor_vec_t hi,
                                            input logic [BANK_W-1:0] bank);
    sensor_vec_t m;
    unique case (bank)
      3'd0:    m = lo[15:0];
      3'd1:    m = lo[31:16];
      3'd2:    m = lo[47:32];
      3'd3:    m = lo[63:48];
      3'd4:    m = hi;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

/* rtl/sbcd_in_if.sv */
// ---------------------------------------------------------------------------
// Sensor bank change detector - input channel
// One word per reply byte or frame restart.
// ---------------------------------------------------------------------------
`default_nettype none

interface sbcd_in_if import sbcd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [BYTE_W-1:0] raw_byte;
  logic [TICK_W-1:0] tick;

  modport source (output valid, output req_type, output raw_byte, output tick,
                  input ready);
  modport sink   (input valid, input req_type, input raw_byte, input tick,
                  output ready);
endinterface

`default_nettype wire

/* rtl/sbcd_out_if.sv */
// ---------------------------------------------------------------------------
// Sensor bank change detector - result channel
// One word per reported sensor change.
// ---------------------------------------------------------------------------
`default_nettype none

interface sbcd_out_if import sbcd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BANK_W-1:0] bank;
  logic [NUM_W-1:0]  sensor_no;
  logic              level;
  logic [TICK_W-1:0] last_rise_tick;
  logic              last_of_run;

  modport source (output valid, output bank, output sensor_no, output level,
                  output last_rise_tick, output last_of_run, input ready);
  modport sink   (input valid, input bank, input sensor_no, input level,
                  input last_rise_tick, input last_of_run, output ready);
endinterface

`default_nettype wire

/* rtl/sbcd_cfg_if.sv */
// ---------------------------------------------------------------------------
// Sensor bank change detector - configuration write channel
// Register index and write data.
// ---------------------------------------------------------------------------
`default_nettype none

interface sbcd_cfg_if import sbcd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* rtl/sbcd_front.sv */
// ---------------------------------------------------------------------------
// Sensor bank change detector - front end
// Tracks byte position, assembles bank level words, updates stored levels
// and queues a job with the new levels, unmuted changes and acted-on changes.
// ---------------------------------------------------------------------------
`default_nettype none

module sbcd_front import sbcd_pkg::*; #(
  parameter int BANKS = MAX_BANKS
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  sbcd_in_if.sink     in_ch,
  sbcd_cfg_if.sink    cfg_ch,
  input  wire logic   q_full,
  output logic        q_push,
  output sbcd_job_t   q_job
);

  localparam int BW = (BANKS > 1) ? $clog2(BANKS) : 1;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(2 * BANKS - 1);

  logic [POS_W-1:0]  pos_r;
  logic [BYTE_W-1:0] held_r;
  sensor_vec_t       levels_r [BANKS];
  logic [LOW_W-1:0]  present_low_r;
  sensor_vec_t       present_high_r;
  logic [LOW_W-1:0]  mute_low_r;
  sensor_vec_t       mute_high_r;

  logic              accept;
  logic              second;
  logic [BANK_W-1:0] bank;
  logic [BW-1:0]     bidx;
  sensor_vec_t       word;
  sensor_vec_t       old_lv;
  sensor_vec_t       pres;
  sensor_vec_t       mute;
  sensor_vec_t       change;
  sensor_vec_t       act;

  assign in_ch.ready  = !q_full;
  assign cfg_ch.ready = 1'b1;
  assign accept = in_ch.valid && in_ch.ready;
  assign second = (in_ch.req_type == REQ_BYTE) && pos_r[0];

  assign bank   = pos_r[POS_W-1:1];
  assign bidx   = bank[BW-1:0];
  assign word   = {flip_byte(in_ch.raw_byte), held_r};
  assign old_lv = levels_r[bidx];
  assign pres   = bank_mask(present_low_r, present_high_r, bank);
  assign mute   = bank_mask(mute_low_r, mute_high_r, bank);
  assign change = (word ^ old_lv) & pres;
  // muted falls need no action at all in the back end
  assign act    = change & (~mute | word);

  assign q_push       = accept && second && (act != '0);
  assign q_job.bank   = bank;
  assign q_job.levels = word;
  assign q_job.act    = act;
  assign q_job.emit   = change & ~mute;
  assign q_job.tick   = in_ch.tick;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      held_r <= '0;
      for (int b = 0; b < BANKS; b++) levels_r[b] <= '0;
    end else if (accept) begin
      if (in_ch.req_type == REQ_RESTART) begin
        pos_r <= '0;
      end else if (!pos_r[0]) begin
        held_r <= flip_byte(in_ch.raw_byte);
        pos_r  <= pos_r + POS_W'(1);
      end else begin
        pos_r          <= (pos_r == POS_LAST) ? '0 : pos_r + POS_W'(1);
        levels_r[bidx] <= old_lv ^ change;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_low_r  <= '1;
      present_high_r <= '1;
      mute_low_r     <= '0;
      mute_high_r    <= '0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        REG_PRESENT_LOW:  present_low_r  <= cfg_ch.data;
        REG_PRESENT_HIGH: present_high_r <= cfg_ch.data[SENSORS-1:0];
        REG_MUTE_LOW:     mute_low_r     <= cfg_ch.data;
        REG_MUTE_HIGH:    mute_high_r    <= cfg_ch.data[SENSORS-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/sbcd_fifo.sv */
// ---------------------------------------------------------------------------
// Sensor bank change detector - job queue
// Short queue of bank jobs between front and back end.
// ---------------------------------------------------------------------------
`default_nettype none
`include "sensor_bank_change_detector_defines.svh"

module sbcd_fifo import sbcd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire sbcd_job_t  din,
  output logic            full,
  input  wire logic       pop,
  output sbcd_job_t       dout,
  output logic            empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

  sbcd_job_t      mem_r [DEPTH];
  logic [PW-1:0]  wr_r;
  logic [PW-1:0]  rd_r;
  logic [CW-1:0]  cnt_r;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= (wr_r == PTR_LAST) ? '0 : wr_r + PW'(1);
      if (pop)  rd_r <= (rd_r == PTR_LAST) ? '0 : rd_r + PW'(1);
      if (push && !pop)      cnt_r <= cnt_r + CW'(1);
      else if (pop && !push) cnt_r <= cnt_r - CW'(1);
    end
  end

  `SBCD_ASSERT_ALWAYS(a_cnt_range, cnt_r <= CW'(DEPTH), "queue count above depth")
  `SBCD_ASSERT_IMPL(a_no_overflow, push, !full, "push into full queue")
  `SBCD_ASSERT_IMPL(a_no_underflow, pop, !empty, "pop from empty queue")

endmodule

`default_nettype wire

/* rtl/sbcd_back.sv */
// ---------------------------------------------------------------------------
// Sensor bank change detector - back end
// Walks a job's sensors lowest first, one a cycle unless the output stalls:
// records rise ticks and loads the result register for each unmuted change.
// ---------------------------------------------------------------------------
`default_nettype none
`include "sensor_bank_change_detector_defines.svh"

module sbcd_back import sbcd_pkg::*; #(
  parameter int BANKS = MAX_BANKS
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire sbcd_job_t q_job,
  input  wire logic      q_empty,
  output logic           q_pop,
  sbcd_out_if.source     out_ch
);

  localparam int DEPTH = BANKS * SENSORS;
  localparam int AW    = $clog2(DEPTH);

  logic              cur_valid_r;
  sbcd_job_t         cur_r;
  sensor_vec_t       rem_r;

  logic [TICK_W-1:0] mem [DEPTH];
  logic              vld_r [DEPTH];
  logic [TICK_W-1:0] rd_data_r;
  logic              rd_vld_r;

  logic              out_valid_r;
  logic [BANK_W-1:0] out_bank_r;
  logic [NUM_W-1:0]  out_num_r;
  logic              out_level_r;
  logic [TICK_W-1:0] out_tick_r;
  logic              out_last_r;

  logic              adv;
  sensor_vec_t       sel;
  sensor_vec_t       rem_nxt;
  logic [SIDX_W-1:0] idx;
  logic              is_emit;
  logic              is_rise;
  logic [AW-1:0]     slot;

  assign q_pop   = !cur_valid_r && !q_empty;
  assign adv     = cur_valid_r && (!out_valid_r || out_ch.ready);
  assign sel     = rem_r & (~rem_r + SENSORS'(1));
  assign rem_nxt = rem_r & ~sel;
  assign is_emit = |(sel & cur_r.emit);
  assign is_rise = |(sel & cur_r.levels);
  assign slot    = AW'({cur_r.bank, idx});

  always_comb begin
    idx = '0;
    for (int i = 0; i < SENSORS; i++) begin
      if (sel[i]) idx = idx | SIDX_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
    end else if (q_pop) begin
      cur_valid_r <= 1'b1;
    end else if (adv && (rem_nxt == '0)) begin
      cur_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_job;
      rem_r <= q_job.act;
    end else if (adv) begin
      rem_r <= rem_nxt;
    end
  end

  // rise tick store; an entry not yet written is reported as tick zero
  always_ff @(posedge clk) begin
    if (adv && is_rise) mem[slot] <= cur_r.tick;
    if (adv) rd_data_r <= mem[slot];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < DEPTH; s++) vld_r[s] <= 1'b0;
      rd_vld_r <= 1'b0;
    end else if (adv) begin
      if (is_rise) vld_r[slot] <= 1'b1;
      rd_vld_r <= vld_r[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && is_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && is_emit) begin
      out_bank_r  <= cur_r.bank;
      out_num_r   <= NUM_W'(idx) + NUM_W'(1);
      out_level_r <= is_rise;
      out_tick_r  <= cur_r.tick;
      out_last_r  <= ((rem_nxt & cur_r.emit) == '0);
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.bank           = out_bank_r;
  assign out_ch.sensor_no      = out_num_r;
  assign out_ch.level          = out_level_r;
  assign out_ch.last_rise_tick = out_level_r ? out_tick_r :
                                 (rd_vld_r ? rd_data_r : '0);
  assign out_ch.last_of_run    = out_last_r;

  `SBCD_ASSERT_IMPL(a_job_has_work, cur_valid_r, rem_r != '0, "active job with no work")
  `SBCD_ASSERT_NEXT(a_rise_marks_valid, adv && is_rise, vld_r[$past(slot)], "rise not marked")
  `SBCD_ASSERT_NEXT(a_emit_loads_out, adv && is_emit, out_valid_r, "update not presented")

endmodule

`default_nettype wire

/* rtl/sensor_bank_change_detector.sv */
// ---------------------------------------------------------------------------
// Sensor bank change detector - top level
// Turns sensor scan reply bytes into per-sensor level change reports.
// ---------------------------------------------------------------------------
// The front end takes one input word per cycle unless the job queue is full:
// restart words and first bytes of a bank finish at once, a bank's second byte
// is compared with the stored levels in that cycle and, if any present sensor
// changed other than by a muted fall, queued as a job (QUEUE_DEPTH jobs deep).
// The back end loads a job and then walks each changed sensor that is reported
// or rising; reports leave from the output register at up to one per cycle
// while the receiver takes them. The rise-tick store is a BANKS*16 entry
// memory with one port, read into a register alongside each report; its
// per-entry valid bits clear at reset, so no clearing pass is needed.
`default_nettype none

module sensor_bank_change_detector import sbcd_pkg::*; #(
  parameter int BANKS       = MAX_BANKS,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  sbcd_in_if.sink     in_ch,
  sbcd_cfg_if.sink    cfg_ch,
  sbcd_out_if.source  out_ch
);

  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_empty;
  sbcd_job_t job_in;
  sbcd_job_t job_out;

  sbcd_front #(.BANKS(BANKS)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (job_in)
  );

  sbcd_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (job_in),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (job_out),
    .empty (q_empty)
  );

  sbcd_back #(.BANKS(BANKS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_job   (job_out),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire
